// ===== rtl/gclt_pkg.sv =====
`timescale 1ns / 1ps
// Package for the gate crossing lap timer: widths, constants, register codes
// and the structs passed between the timer modules. Depends on nothing.
package gclt_pkg;

  localparam int TIME_W         = 32;
  localparam int DIST_W         = 32;
  localparam int CFG_W          = 8;
  localparam int CFG_IDX_W      = 1;
  localparam int COUNT_W        = 16;
  localparam int HISTORY_LAPS_D = 3;

  localparam int MS_PER_S = 1000;
  localparam int CM_PER_M = 100;

  // scaled register widths: 255 * 1000 and 255 * 100
  localparam int MIN_LAP_MS_W = 18;
  localparam int RADIUS_CM_W  = 15;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_LAP_SECONDS = 1'b0,
    CFG_GATE_RADIUS_M   = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [TIME_W-1:0] fix_time_ms;
    logic [DIST_W-1:0] distance_cm;
    logic              setting_gate;
    logic              reset_request;
  } fix_t;

  typedef struct packed {
    logic              record;
    logic              clear;
    logic [TIME_W-1:0] lap_ms;
  } lap_evt_t;

endpackage

// ===== rtl/gclt_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the lap timer: position fix words in,
// lap report words out. Depends on gclt_pkg.
interface gclt_fix_if;
  logic                          valid;
  logic                          ready;
  logic [gclt_pkg::TIME_W-1:0]   fix_time_ms;
  logic [gclt_pkg::DIST_W-1:0]   distance_cm;
  logic                          setting_gate;
  logic                          reset_request;

  modport source (output valid, fix_time_ms, distance_cm, setting_gate, reset_request,
                  input ready);
  modport sink   (input valid, fix_time_ms, distance_cm, setting_gate, reset_request,
                  output ready);
endinterface

interface gclt_lap_if;
  logic                          valid;
  logic                          ready;
  logic                          lap_done;
  logic [gclt_pkg::TIME_W-1:0]   last_lap_ms;
  logic [gclt_pkg::TIME_W-1:0]   best_lap_ms;
  logic [gclt_pkg::TIME_W-1:0]   best_run_ms;
  logic [gclt_pkg::COUNT_W-1:0]  lap_count;
  logic                          running;
  logic                          inside_gate;

  modport source (output valid, lap_done, last_lap_ms, best_lap_ms, best_run_ms, lap_count,
                  running, inside_gate, input ready);
  modport sink   (input valid, lap_done, last_lap_ms, best_lap_ms, best_run_ms, lap_count,
                  running, inside_gate, output ready);
endinterface

// ===== rtl/gclt_gate.sv =====
`timescale 1ns / 1ps
// Gate tracking: arming, tolerance circle, closest approach and crossing
// detection. Emits lap events to the statistics block. Depends on gclt_pkg.
module gclt_gate (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              step,
  input  gclt_pkg::fix_t                    fix,
  input  logic [gclt_pkg::MIN_LAP_MS_W-1:0] min_lap_ms,
  input  logic [gclt_pkg::RADIUS_CM_W-1:0]  radius_cm,
  output gclt_pkg::lap_evt_t                lap_evt,
  output logic                              timer_on,
  output logic                              was_inside
);

  logic                          was_inside_r, was_inside_nxt;
  logic                          timer_on_r, timer_on_nxt;
  logic [gclt_pkg::DIST_W-1:0]   closest_cm_r, closest_cm_nxt;
  logic [gclt_pkg::TIME_W-1:0]   closest_time_r, closest_time_nxt;
  logic [gclt_pkg::TIME_W-1:0]   last_cross_r, last_cross_nxt;

  logic                          active;
  logic                          armed;
  logic                          in_circle;
  logic                          track;
  logic                          record;
  logic [gclt_pkg::TIME_W-1:0]   elapsed;

  // qualify the word and test the arming window and circle
  assign active    = step && !fix.setting_gate;
  assign elapsed   = fix.fix_time_ms - last_cross_r;
  assign armed     = !timer_on_r || (elapsed > gclt_pkg::TIME_W'(min_lap_ms));
  assign in_circle = fix.distance_cm < gclt_pkg::DIST_W'(radius_cm);
  assign track     = active && !fix.reset_request && armed;
  assign record    = track && !in_circle && was_inside_r && timer_on_r;

  // advance crossing state
  always_comb begin
    was_inside_nxt   = was_inside_r;
    timer_on_nxt     = timer_on_r;
    closest_cm_nxt   = closest_cm_r;
    closest_time_nxt = closest_time_r;
    last_cross_nxt   = last_cross_r;
    if (active && fix.reset_request) begin
      timer_on_nxt   = 1'b0;
      last_cross_nxt = '0;
    end else if (track) begin
      if (in_circle) begin
        if (!was_inside_r || fix.distance_cm < closest_cm_r) begin
          closest_cm_nxt   = fix.distance_cm;
          closest_time_nxt = fix.fix_time_ms;
        end
        was_inside_nxt = 1'b1;
      end else begin
        if (was_inside_r) begin
          last_cross_nxt = closest_time_r;
          timer_on_nxt   = 1'b1;
        end
        was_inside_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      was_inside_r   <= 1'b0;
      timer_on_r     <= 1'b0;
      closest_cm_r   <= '1;
      closest_time_r <= '0;
      last_cross_r   <= '0;
    end else begin
      was_inside_r   <= was_inside_nxt;
      timer_on_r     <= timer_on_nxt;
      closest_cm_r   <= closest_cm_nxt;
      closest_time_r <= closest_time_nxt;
      last_cross_r   <= last_cross_nxt;
    end
  end

  // lap runs from the previous crossing to this closest approach
  assign lap_evt.record = record;
  assign lap_evt.clear  = active && fix.reset_request;
  assign lap_evt.lap_ms = closest_time_r - last_cross_r;

  assign timer_on   = timer_on_r;
  assign was_inside = was_inside_r;

endmodule

// ===== rtl/gclt_stats.sv =====
`timescale 1ns / 1ps
// Lap statistics: lap history shift line, window sum, best lap, best run and
// saturating lap count. Depends on gclt_pkg.
module gclt_stats #(
  parameter int HISTORY_LAPS = gclt_pkg::HISTORY_LAPS_D
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  gclt_pkg::lap_evt_t            lap_evt,
  output logic [gclt_pkg::TIME_W-1:0]   last_lap_ms,
  output logic [gclt_pkg::TIME_W-1:0]   best_lap_ms,
  output logic [gclt_pkg::TIME_W-1:0]   best_run_ms,
  output logic [gclt_pkg::COUNT_W-1:0]  lap_count
);

  logic [gclt_pkg::TIME_W-1:0]  hist_r [HISTORY_LAPS];
  logic [gclt_pkg::TIME_W-1:0]  window_r, window_nxt;
  logic [gclt_pkg::TIME_W-1:0]  best_single_r, best_single_nxt;
  logic [gclt_pkg::TIME_W-1:0]  best_sum_r, best_sum_nxt;
  logic [gclt_pkg::COUNT_W-1:0] count_r, count_nxt;
  logic [gclt_pkg::TIME_W-1:0]  run_sum;
  logic [gclt_pkg::COUNT_W-1:0] count_inc;

  // window sum slides: drop the oldest lap, add the new one
  assign count_inc  = (count_r == gclt_pkg::COUNT_MAX) ? count_r : count_r + 1'b1;
  assign window_nxt = window_r - hist_r[HISTORY_LAPS-1] + lap_evt.lap_ms;
  assign run_sum    = (count_inc >= gclt_pkg::COUNT_W'(HISTORY_LAPS)) ? window_nxt : '0;

  always_comb begin
    count_nxt       = count_r;
    best_single_nxt = best_single_r;
    best_sum_nxt    = best_sum_r;
    if (lap_evt.clear) begin
      count_nxt       = '0;
      best_single_nxt = '0;
      best_sum_nxt    = '0;
    end else if (lap_evt.record) begin
      count_nxt = count_inc;
      if (lap_evt.lap_ms < best_single_r || best_single_r == '0) begin
        best_single_nxt = lap_evt.lap_ms;
      end
      if (run_sum != '0 && (run_sum < best_sum_r || best_sum_r == '0)) begin
        best_sum_nxt = run_sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r       <= '0;
      best_single_r <= '0;
      best_sum_r    <= '0;
      window_r      <= '0;
    end else begin
      count_r       <= count_nxt;
      best_single_r <= best_single_nxt;
      best_sum_r    <= best_sum_nxt;
      if (lap_evt.clear) begin
        window_r <= '0;
      end else if (lap_evt.record) begin
        window_r <= window_nxt;
      end
    end
  end

  // shift the lap history, newest at the head
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < HISTORY_LAPS; i++) begin
        hist_r[i] <= '0;
      end
    end else if (lap_evt.clear) begin
      for (int i = 0; i < HISTORY_LAPS; i++) begin
        hist_r[i] <= '0;
      end
    end else if (lap_evt.record) begin
      hist_r[0] <= lap_evt.lap_ms;
      for (int i = 1; i < HISTORY_LAPS; i++) begin
        hist_r[i] <= hist_r[i-1];
      end
    end
  end

  assign last_lap_ms = hist_r[0];
  assign best_lap_ms = best_single_r;
  assign best_run_ms = best_sum_r;
  assign lap_count   = count_r;

endmodule

// ===== rtl/gate_crossing_lap_timer.sv =====
`timescale 1ns / 1ps
// Top level of the gate crossing lap timer: configuration registers, input
// word register, result handshake. Depends on gclt_pkg, gclt_if, gclt_gate, gclt_stats.

// Takes one position fix word per clock while reports are taken, and gives exactly
// one report word per fix. A fix sits in the input register while the timer logic
// works on it, and waits there while a report is stalled; its report is valid from
// the edge that updates the timer state, and fixes can follow back to back at one
// per cycle as long as the sink takes the reports.
// The timer state itself is the report register: it holds while the report
// waits, and the input register takes the next fix in the meantime. The
// minimum lap time and gate radius are pre-scaled to ms and cm when written;
// write them only while no fix is in flight. There is no clearing pass after reset.
module gate_crossing_lap_timer #(
  parameter int HISTORY_LAPS = gclt_pkg::HISTORY_LAPS_D
) (
  input  logic                            clk,
  input  logic                            rst_n,
  gclt_fix_if.sink                        in_fix,
  gclt_lap_if.source                      out_lap,
  input  logic                            cfg_we,
  input  logic [gclt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gclt_pkg::CFG_W-1:0]      cfg_wdata
);

  logic [gclt_pkg::MIN_LAP_MS_W-1:0] min_lap_ms_r;
  logic [gclt_pkg::RADIUS_CM_W-1:0]  radius_cm_r;

  gclt_pkg::fix_t     fix_r;
  logic               fix_valid_r;
  logic               out_valid_r;
  logic               lap_done_r;
  logic               advance;
  logic               in_take;
  gclt_pkg::lap_evt_t lap_evt;
  logic               timer_on;
  logic               was_inside;

  // scale configuration on write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_lap_ms_r <= '0;
      radius_cm_r  <= gclt_pkg::RADIUS_CM_W'(gclt_pkg::CM_PER_M);
    end else if (cfg_we) begin
      unique case (gclt_pkg::cfg_reg_t'(cfg_index))
        gclt_pkg::CFG_MIN_LAP_SECONDS: begin
          min_lap_ms_r <= gclt_pkg::MIN_LAP_MS_W'(cfg_wdata * gclt_pkg::MS_PER_S);
        end
        gclt_pkg::CFG_GATE_RADIUS_M: begin
          radius_cm_r <= gclt_pkg::RADIUS_CM_W'(cfg_wdata * gclt_pkg::CM_PER_M);
        end
        default: begin
          min_lap_ms_r <= min_lap_ms_r;
        end
      endcase
    end
  end

  // process the held word when the report slot is free or being taken
  assign advance      = fix_valid_r && (!out_valid_r || out_lap.ready);
  assign in_fix.ready = !fix_valid_r || advance;
  assign in_take      = in_fix.valid && in_fix.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fix_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      lap_done_r  <= 1'b0;
    end else begin
      if (in_take) begin
        fix_valid_r <= 1'b1;
      end else if (advance) begin
        fix_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        lap_done_r  <= lap_evt.record;
      end else if (out_lap.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // hold the input word
  always_ff @(posedge clk) begin
    if (in_take) begin
      fix_r.fix_time_ms   <= in_fix.fix_time_ms;
      fix_r.distance_cm   <= in_fix.distance_cm;
      fix_r.setting_gate  <= in_fix.setting_gate;
      fix_r.reset_request <= in_fix.reset_request;
    end
  end

  gclt_gate u_gate (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (advance),
    .fix        (fix_r),
    .min_lap_ms (min_lap_ms_r),
    .radius_cm  (radius_cm_r),
    .lap_evt    (lap_evt),
    .timer_on   (timer_on),
    .was_inside (was_inside)
  );

  gclt_stats #(
    .HISTORY_LAPS (HISTORY_LAPS)
  ) u_stats (
    .clk         (clk),
    .rst_n       (rst_n),
    .lap_evt     (lap_evt),
    .last_lap_ms (out_lap.last_lap_ms),
    .best_lap_ms (out_lap.best_lap_ms),
    .best_run_ms (out_lap.best_run_ms),
    .lap_count   (out_lap.lap_count)
  );

  assign out_lap.valid       = out_valid_r;
  assign out_lap.lap_done    = lap_done_r;
  assign out_lap.running     = timer_on;
  assign out_lap.inside_gate = was_inside;

`ifndef SYNTH
  a_lap_needs_timer: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && lap_done_r) |-> (timer_on && out_lap.lap_count != '0))
    else $error("lap reported while timer stopped or count zero");

  a_run_needs_history: assert property (@(posedge clk) disable iff (!rst_n)
    (out_lap.best_run_ms != '0) |->
      (out_lap.lap_count >= gclt_pkg::COUNT_W'(HISTORY_LAPS)))
    else $error("best run set before the history window filled");

  a_record_leaves_gate: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && lap_evt.record) |=> (!was_inside && timer_on))
    else $error("lap recorded without leaving the gate");

  a_stall_holds_word: assert property (@(posedge clk) disable iff (!rst_n)
    !in_fix.ready |-> (fix_valid_r && out_valid_r))
    else $error("input stalled with a free slot");
`endif

endmodule
